[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define FVN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fvn assertion failed");

// clocked assertion that also runs through reset
`define FVN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("fvn assertion failed");

`endif

[sv/fvn_pkg.sv]
// shared constants, types and tables of the fractal value noise block
`default_nettype none
package fvn_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int NUM_OCT     = 8;
  localparam int OCT_W       = 4;
  localparam int IDX_W       = 3;
  localparam int COORD_W     = 32;
  localparam int VAL_W       = 16;
  localparam int SUM_W       = VAL_W + NUM_OCT;
  localparam int RECIP_SHIFT = 32;
  localparam int LANE_STAGES = 5;
  localparam int NORM_STAGES = 4;
  localparam int LATENCY     = 1 + LANE_STAGES + NORM_STAGES;

  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [31:0] HASH_MUL_M = 32'd1274126177;

  localparam logic [OCT_W-1:0] OCT_MIN   = OCT_W'(2);
  localparam logic [OCT_W-1:0] OCT_MAX   = OCT_W'(NUM_OCT);
  localparam logic [OCT_W-1:0] OCT_RESET = OCT_W'(4);

  typedef struct packed {
    logic             valid;
    logic [OCT_W-1:0] n;
  } ctl_t;

  // floor(2^32 / (2^n - 1)) for the clamped octave counts
  function automatic logic [31:0] recip(input logic [OCT_W-1:0] n);
    logic [31:0] r;
    case (n)
      OCT_W'(2): r = 32'd1431655765;
      OCT_W'(3): r = 32'd613566756;
      OCT_W'(4): r = 32'd286331153;
      OCT_W'(5): r = 32'd138547332;
      OCT_W'(6): r = 32'd68174084;
      OCT_W'(7): r = 32'd33818640;
      OCT_W'(8): r = 32'd16843009;
      default:   r = 32'd1431655765;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/fvn_octave.sv]
// one octave lane: lattice hash, smoothstep weights and bilinear blend
`default_nettype none
module fvn_octave (
  input  wire logic                            clk_i,
  input  wire logic [fvn_pkg::IDX_W-1:0]       oct_idx_i,
  input  wire logic [fvn_pkg::COORD_W-1:0]     coord_x_i,
  input  wire logic [fvn_pkg::COORD_W-1:0]     coord_y_i,
  output logic      [fvn_pkg::VAL_W-1:0]       value_o
);
  localparam int F  = fvn_pkg::FRAC_BITS;
  localparam int CW = fvn_pkg::COORD_W;
  localparam int VW = fvn_pkg::VAL_W;

  logic [2*CW-1:0] px, py;
  assign px = {{CW{1'b0}}, coord_x_i} << oct_idx_i;
  assign py = {{CW{1'b0}}, coord_y_i} << oct_idx_i;

  // stage 1: corner products and squared fractions
  logic [31:0]  ax_q, by_q;
  logic [F-1:0] fx_q, fy_q, tx_q, ty_q;
  logic [2*F-1:0] sqx, sqy;
  assign sqx = {{F{1'b0}}, px[F-1:0]} * {{F{1'b0}}, px[F-1:0]};
  assign sqy = {{F{1'b0}}, py[F-1:0]} * {{F{1'b0}}, py[F-1:0]};

  always_ff @(posedge clk_i) begin
    ax_q <= px[F+31:F] * fvn_pkg::HASH_MUL_X;
    by_q <= py[F+31:F] * fvn_pkg::HASH_MUL_Y;
    fx_q <= px[F-1:0];
    fy_q <= py[F-1:0];
    tx_q <= sqx[2*F-1:F];
    ty_q <= sqy[2*F-1:F];
  end

  // stage 2: corner hash sums with first xor-shift, smoothstep weights
  logic [31:0] h [4];
  logic [31:0] g_d [4];
  logic [31:0] g_q [4];
  logic [F+1:0] kx, ky;
  logic [2*F+1:0] wpx, wpy;
  logic [F-1:0] wu_q, wv_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      h[c] = ax_q + by_q + ((c % 2) != 0 ? fvn_pkg::HASH_MUL_X : 32'd0)
                        + ((c / 2) != 0 ? fvn_pkg::HASH_MUL_Y : 32'd0);
      g_d[c] = h[c] ^ (h[c] >> 13);
    end
  end

  assign kx  = (F+2)'(3) << F;
  assign ky  = kx;
  assign wpx = {{(F+2){1'b0}}, tx_q} * {{F{1'b0}}, kx - {1'b0, fx_q, 1'b0}};
  assign wpy = {{(F+2){1'b0}}, ty_q} * {{F{1'b0}}, ky - {1'b0, fy_q, 1'b0}};

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) g_q[c] <= g_d[c];
    wu_q <= wpx[2*F-1:F];
    wv_q <= wpy[2*F-1:F];
  end

  // stage 3: hash multiply
  logic [31:0] m_q [4];
  logic [F-1:0] wu3_q, wv3_q;
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) m_q[c] <= g_q[c] * fvn_pkg::HASH_MUL_M;
    wu3_q <= wu_q;
    wv3_q <= wv_q;
  end

  // stage 4: final mix and row blends, a + (b-a)*w keeps one product per row
  logic [VW-1:0] hv [4];
  logic signed [VW+F+2:0] r0, r1;
  logic [VW-1:0] row0_q, row1_q;
  logic [F-1:0]  wv4_q;

  always_comb begin
    for (int c = 0; c < 4; c++) hv[c] = m_q[c][VW-1:0] ^ m_q[c][31:16];
    r0 = ($signed({3'b0, hv[0], {F{1'b0}}}))
       + ($signed({{(F+2){1'b0}}, hv[1]}) - $signed({{(F+2){1'b0}}, hv[0]}))
         * $signed({{(VW+3){1'b0}}, wu3_q});
    r1 = ($signed({3'b0, hv[2], {F{1'b0}}}))
       + ($signed({{(F+2){1'b0}}, hv[3]}) - $signed({{(F+2){1'b0}}, hv[2]}))
         * $signed({{(VW+3){1'b0}}, wu3_q});
  end

  always_ff @(posedge clk_i) begin
    row0_q <= r0[VW+F-1:F];
    row1_q <= r1[VW+F-1:F];
    wv4_q  <= wv3_q;
  end

  // stage 5: blend along y
  logic signed [VW+F+2:0] v;
  assign v = ($signed({3'b0, row0_q, {F{1'b0}}}))
           + ($signed({{(F+2){1'b0}}, row1_q}) - $signed({{(F+2){1'b0}}, row0_q}))
             * $signed({{(VW+3){1'b0}}, wv4_q});

  always_ff @(posedge clk_i) begin
    value_o <= v[VW+F-1:F];
  end

endmodule
`default_nettype wire

[sv/fvn_norm.sv]
// weighted octave sum and division by the total weight
`default_nettype none
module fvn_norm (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire fvn_pkg::ctl_t            ctl_i,
  input  wire logic [fvn_pkg::VAL_W-1:0] oct_val_i [fvn_pkg::NUM_OCT],
  output logic                          done_o,
  output logic [fvn_pkg::VAL_W-1:0]     value_o
);
  localparam int NO = fvn_pkg::NUM_OCT;
  localparam int SW = fvn_pkg::SUM_W;
  localparam int NP = NO / 2;
  localparam int PW = SW + 32;

  fvn_pkg::ctl_t ctl_a_q, ctl_b_q, ctl_c_q;

  // stage a: terms weighted as if all octaves counted, summed in pairs
  logic [SW-1:0] term [NO];
  logic [SW-1:0] pair_q [NP];
  always_comb begin
    for (int i = 0; i < NO; i++) begin
      if (fvn_pkg::OCT_W'(i) < ctl_i.n) begin
        term[i] = SW'(oct_val_i[i]) << (NO - 1 - i);
      end else begin
        term[i] = '0;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NP; p++) pair_q[p] <= term[2*p] + term[2*p+1];
  end

  // stage b: total, then drop the unused low weights
  logic [SW-1:0] tot;
  logic [SW-1:0] s_q;
  always_comb begin
    tot = '0;
    for (int p = 0; p < NP; p++) tot = tot + pair_q[p];
  end
  always_ff @(posedge clk_i) begin
    s_q <= tot >> (fvn_pkg::OCT_W'(NO) - ctl_a_q.n);
  end

  // stage c: reciprocal multiply
  logic [PW-1:0] prod_q;
  logic [SW-1:0] s2_q;
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(s_q) * PW'(fvn_pkg::recip(ctl_b_q.n));
    s2_q   <= s_q;
  end

  // stage d: estimate is exact or one low
  logic [SW-1:0] q0, d, rem;
  assign q0  = prod_q[PW-1:32];
  assign d   = (SW'(1) << ctl_c_q.n) - SW'(1);
  assign rem = s2_q - q0 * d;
  always_ff @(posedge clk_i) begin
    value_o <= (rem >= d) ? fvn_pkg::VAL_W'(q0 + SW'(1)) : fvn_pkg::VAL_W'(q0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
      done_o  <= 1'b0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
      ctl_c_q <= ctl_b_q;
      done_o  <= ctl_c_q.valid;
    end
  end

endmodule
`default_nettype wire

[sv/fractal_value_noise.sv]
// top level of the fractal value noise pipeline
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+------------------------------
//  input    | coord_x_i, coord_y_i               | start, transfer when !busy
//  result   | noise_value_o                      | done_o strobe, one cycle
//  config   | octave_count_i                     | octave_count_we_i, no wait
//
// one point per cycle; done_o rises together with the result once the point has
// passed the input register, five lane stages and four normalize stages
// all octaves run in parallel lanes, so the octave count does not change rate
// busy stays low; the pipeline never stalls and the receiver cannot stall
// reset clears valid bits and sets the octave count to 4
`default_nettype none
module fractal_value_noise (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [fvn_pkg::COORD_W-1:0]   coord_x_i,
  input  wire logic [fvn_pkg::COORD_W-1:0]   coord_y_i,
  input  wire logic                          octave_count_we_i,
  input  wire logic [fvn_pkg::OCT_W-1:0]     octave_count_i,
  output logic                               done_o,
  output logic [fvn_pkg::VAL_W-1:0]          noise_value_o
);
  localparam int LS = fvn_pkg::LANE_STAGES;

  logic [fvn_pkg::OCT_W-1:0] oct_cnt_q;
  logic [fvn_pkg::OCT_W-1:0] n_eff;
  logic [fvn_pkg::COORD_W-1:0] x_q, y_q;
  fvn_pkg::ctl_t ctl_q [LS+1];
  logic [fvn_pkg::VAL_W-1:0] oct_val [fvn_pkg::NUM_OCT];

  assign busy = 1'b0;

  always_comb begin
    if (oct_cnt_q < fvn_pkg::OCT_MIN) begin
      n_eff = fvn_pkg::OCT_MIN;
    end else if (oct_cnt_q > fvn_pkg::OCT_MAX) begin
      n_eff = fvn_pkg::OCT_MAX;
    end else begin
      n_eff = oct_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_cnt_q <= fvn_pkg::OCT_RESET;
      for (int s = 0; s <= LS; s++) ctl_q[s] <= '0;
    end else begin
      if (octave_count_we_i) begin
        oct_cnt_q <= octave_count_i;
      end
      ctl_q[0].valid <= start && !busy;
      ctl_q[0].n     <= n_eff;
      for (int s = 1; s <= LS; s++) ctl_q[s] <= ctl_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= coord_x_i;
    y_q <= coord_y_i;
  end

  for (genvar i = 0; i < fvn_pkg::NUM_OCT; i++) begin : g_lane
    fvn_octave u_oct (
      .clk_i     (clk_i),
      .oct_idx_i (fvn_pkg::IDX_W'(i)),
      .coord_x_i (x_q),
      .coord_y_i (y_q),
      .value_o   (oct_val[i])
    );
  end

  fvn_norm u_norm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_q[LS]),
    .oct_val_i (oct_val),
    .done_o    (done_o),
    .value_o   (noise_value_o)
  );

endmodule
`default_nettype wire

[sv/fvn_checker.sv]
// port-level checker for the fractal value noise block, with its bind
`default_nettype none
`include "assert_macros.svh"
module fvn_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);
  `FVN_ASSERT(a_never_busy, clk_i, rst_ni, !busy)
  `FVN_ASSERT(a_done_has_source, clk_i, rst_ni, done_o |-> $past(start && !busy, fvn_pkg::LATENCY))
  `FVN_ASSERT_ALWAYS(a_reset_quiet, clk_i, $past(!rst_ni) |-> !done_o)
endmodule

bind fractal_value_noise fvn_checker u_fvn_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);
`default_nettype wire
